>>> sv/adsr_pkg.sv
// Package for the exponential ADSR envelope block: field widths, segment and
// mode codes, configuration register indexes and reset defaults.
// No dependencies.
package adsr_pkg;

    localparam int FRAC_BITS_DEF = 23;

    localparam int COEFF_W = 24;
    localparam int SUS_W   = 25;
    localparam int LVL_W   = 26;
    localparam int LEVEL_W = 24;
    localparam int DIFF_W  = 27;
    localparam int PROD_W  = COEFF_W + 1 + DIFF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef logic signed [LVL_W-1:0]  lvl_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [COEFF_W-1:0]       coeff_t;
    typedef logic signed [SUS_W-1:0]  sus_t;

    typedef enum logic [2:0] {
        SEG_IDLE    = 3'd0,
        SEG_ATTACK  = 3'd1,
        SEG_DECAY   = 3'd2,
        SEG_SUSTAIN = 3'd3,
        SEG_RELEASE = 3'd4
    } seg_t;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_SOFT = 2'd1,
        MODE_HARD = 2'd2,
        MODE_RSVD = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_GOAL   = 3'd4;

    localparam coeff_t ATTACK_COEFF_RST  = 24'd8062;
    localparam coeff_t DECAY_COEFF_RST   = 24'd1747;
    localparam coeff_t RELEASE_COEFF_RST = 24'd1747;
    localparam sus_t   SUSTAIN_LEVEL_RST = 25'sd5872026;
    localparam coeff_t ATTACK_GOAL_RST   = 24'd8472494;

endpackage

>>> sv/adsr_envelope_with_sustain_hold.sv
// Exponential ADSR envelope with sustain hold, at most one one-pole step per tick.
// An input transfer is captured in the input register, and its result then in the result register on the m_ side.
// Throughput: one tick per cycle; the result register stalls while a result is held by
// m_tready low, and the input register stalls then only while it holds a tick.
// Reset: level 0, segment idle, previous gate 0, configuration registers at their defaults.
// Depends on adsr_pkg.
module adsr_envelope_with_sustain_hold #(
    parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // tick input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adsr_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] gate, [7:1] zero
    input  logic [1:0]                        s_tuser,   // [1:0] mode
    // envelope output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adsr_pkg::OUT_DATA_W-1:0]   m_tdata,   // [23:0] level
    output logic [2:0]                        m_tuser    // [2:0] segment
);
    import adsr_pkg::*;

    localparam int EXT_W = 64 - LVL_W;
    localparam logic signed [63:0] ONE_Q    = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] NEG_H_Q  = -((ONE_Q + 64'sd50) / 64'sd100);
    localparam logic signed [63:0] EPS_Q    = (ONE_Q + 64'sd50000) / 64'sd100000;
    localparam logic signed [63:0] LVL_MAXQ = (64'sd1 <<< (LVL_W - 1)) - 64'sd1;
    localparam logic signed [63:0] ONE_CLIP = (ONE_Q > LVL_MAXQ) ? LVL_MAXQ : ONE_Q;

    localparam lvl_t  ONE_LVL   = ONE_CLIP[LVL_W-1:0];
    localparam diff_t NEG_H_D   = NEG_H_Q[DIFF_W-1:0];
    localparam diff_t EPS_D     = EPS_Q[DIFF_W-1:0];
    localparam logic signed [63:0] NEG_EPS_Q = -EPS_Q;
    localparam diff_t NEG_EPS_D = NEG_EPS_Q[DIFF_W-1:0];
    localparam logic [LEVEL_W-1:0] OUT_ONE = ONE_Q[LEVEL_W-1:0];
    localparam prod_t LVL_MAX_P = {{(PROD_W-LVL_W+1){1'b0}}, {(LVL_W-1){1'b1}}};
    localparam prod_t LVL_MIN_P = {{(PROD_W-LVL_W+1){1'b1}}, {(LVL_W-1){1'b0}}};

    // configuration registers
    coeff_t attack_coeff_reg, decay_coeff_reg, release_coeff_reg, attack_goal_reg;
    sus_t   sustain_level_reg;

    // input stage, result stage, envelope state
    logic   in_valid_reg;
    mode_t  in_mode_reg;
    logic   in_gate_reg;
    logic   out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    seg_t   out_seg_reg;
    lvl_t   level_reg, level_next;
    seg_t   seg_reg, seg_next;
    logic   last_gate_reg, last_gate_next;

    logic   advance, fire;
    seg_t   edge_seg;
    coeff_t coeff_sel;
    diff_t  target_sel, diff, snap_diff;
    prod_t  prod, quot, sum;
    lvl_t   stepped;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_level_reg;
    assign m_tuser  = out_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coeff_reg  <= ATTACK_COEFF_RST;
            decay_coeff_reg   <= DECAY_COEFF_RST;
            release_coeff_reg <= RELEASE_COEFF_RST;
            sustain_level_reg <= SUSTAIN_LEVEL_RST;
            attack_goal_reg   <= ATTACK_GOAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ATTACK_COEFF:  attack_coeff_reg  <= cfg_data[COEFF_W-1:0];
                REG_DECAY_COEFF:   decay_coeff_reg   <= cfg_data[COEFF_W-1:0];
                REG_RELEASE_COEFF: release_coeff_reg <= cfg_data[COEFF_W-1:0];
                REG_SUSTAIN_LEVEL: sustain_level_reg <= $signed(cfg_data[SUS_W-1:0]);
                REG_ATTACK_GOAL:   attack_goal_reg   <= cfg_data[COEFF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            seg_reg       <= SEG_IDLE;
            last_gate_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                level_reg     <= level_next;
                seg_reg       <= seg_next;
                last_gate_reg <= last_gate_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= mode_t'(s_tuser);
            in_gate_reg <= s_tdata[0];
        end
        if (fire)
        begin
            out_level_reg <= out_level_next;
            out_seg_reg   <= seg_next;
        end
    end

    // gate edge detection and one-pole step: x + floor(coeff * (target - x) / ONE)
    always_comb
    begin
        if (in_gate_reg && !last_gate_reg)
            edge_seg = SEG_ATTACK;
        else if (!in_gate_reg && last_gate_reg)
            edge_seg = SEG_RELEASE;
        else
            edge_seg = seg_reg;

        priority case (edge_seg)
            SEG_ATTACK:
            begin
                coeff_sel  = attack_coeff_reg;
                target_sel = $signed({{(DIFF_W-COEFF_W){1'b0}}, attack_goal_reg});
            end
            SEG_DECAY:
            begin
                coeff_sel  = decay_coeff_reg;
                target_sel = {{(DIFF_W-SUS_W){sustain_level_reg[SUS_W-1]}}, sustain_level_reg};
            end
            default:
            begin
                coeff_sel  = release_coeff_reg;
                target_sel = NEG_H_D;
            end
        endcase

        diff = target_sel - {{(DIFF_W-LVL_W){level_reg[LVL_W-1]}}, level_reg};
        prod = $signed({1'b0, coeff_sel}) * diff;
        quot = prod >>> FRAC_BITS;
        sum  = {{(PROD_W-LVL_W){level_reg[LVL_W-1]}}, level_reg} + quot;
        if (sum > LVL_MAX_P)
            stepped = LVL_MAX_P[LVL_W-1:0];
        else if (sum < LVL_MIN_P)
            stepped = LVL_MIN_P[LVL_W-1:0];
        else
            stepped = sum[LVL_W-1:0];

        snap_diff = {{(DIFF_W-LVL_W){stepped[LVL_W-1]}}, stepped}
                  - {{(DIFF_W-SUS_W){sustain_level_reg[SUS_W-1]}}, sustain_level_reg};
    end

    // next state
    always_comb
    begin
        level_next     = level_reg;
        seg_next       = seg_reg;
        last_gate_next = last_gate_reg;
        unique case (in_mode_reg)
            MODE_SOFT:
                seg_next = SEG_ATTACK;
            MODE_HARD:
            begin
                seg_next   = SEG_ATTACK;
                level_next = '0;
            end
            default:
            begin
                last_gate_next = in_gate_reg;
                seg_next       = edge_seg;
                unique case (edge_seg)
                    SEG_SUSTAIN:
                        level_next = {sustain_level_reg[SUS_W-1], sustain_level_reg};
                    SEG_ATTACK:
                    begin
                        if ($signed({{EXT_W{stepped[LVL_W-1]}}, stepped}) > ONE_Q)
                        begin
                            level_next = ONE_LVL;
                            seg_next   = SEG_DECAY;
                        end
                        else
                            level_next = stepped;
                    end
                    SEG_DECAY, SEG_RELEASE:
                    begin
                        level_next = stepped;
                        // in decay, snap into sustain when within epsilon of the sustain level
                        if (edge_seg == SEG_DECAY && snap_diff <= EPS_D
                            && snap_diff >= NEG_EPS_D)
                        begin
                            level_next = {sustain_level_reg[SUS_W-1], sustain_level_reg};
                            seg_next   = SEG_SUSTAIN;
                        end
                        if (level_next < 0)
                        begin
                            level_next = '0;
                            seg_next   = SEG_IDLE;
                        end
                    end
                    default:
                        ;
                endcase
            end
        endcase
    end

    // output level: zero in idle, clamped to 0..ONE
    always_comb
    begin
        if (seg_next == SEG_IDLE || level_next < 0)
            out_level_next = '0;
        else if ($signed({{EXT_W{level_next[LVL_W-1]}}, level_next}) > ONE_Q)
            out_level_next = OUT_ONE;
        else
            out_level_next = level_next[LEVEL_W-1:0];
    end

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg == SEG_IDLE |-> level_reg == '0)
        else $error("idle segment with nonzero level");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[LEVEL_W-1:0] <= OUT_ONE)
        else $error("output level above full scale");

    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == SEG_IDLE |-> m_tdata == '0)
        else $error("idle result with nonzero level");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(level_reg) && $stable(seg_reg) && $stable(last_gate_reg))
        else $error("envelope state moved without a transfer");

    a_retrig_gate: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_mode_reg == MODE_SOFT || in_mode_reg == MODE_HARD)
        |=> $stable(last_gate_reg) && seg_reg == SEG_ATTACK)
        else $error("retrigger did not enter attack or touched the gate");

endmodule
